>>> rtl/jpeg_app_segment_extractor_unit_assert.svh
// assertion macros for the application segment extractor checker
// no dependencies; included by the checker file only
`ifndef JPEG_APP_SEGMENT_EXTRACTOR_UNIT_ASSERT_SVH
`define JPEG_APP_SEGMENT_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define JASE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jase port check failed");

// next-cycle implication, disabled while reset is low
`define JASE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jase port check failed");

`endif

>>> rtl/jase_pkg.sv
// shared types, constants and identifier table for the segment extractor
// no dependencies
package jase_pkg;

    localparam int ID_LENGTH = 10;

    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  SOI_CODE      = 8'hD8;
    localparam logic [7:0]  APP_MARKER_RESET = 8'hE0;

    // segment length must cover the length field and the identifier
    localparam logic [15:0] ID_COUNT       = 16'(ID_LENGTH);
    localparam logic [15:0] MIN_ID_SEG_LEN = 16'(ID_LENGTH + 2);
    localparam logic [15:0] LEN_FIELD_SIZE = 16'd2;

    // identifier bytes, positions past the stored ones compare against zero
    localparam logic [7:0] ID_TAB [16] = '{
        8'h51, 8'h75, 8'h69, 8'h63, 8'h6B, 8'h52, 8'h6F, 8'h75,
        8'h74, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_JPEG  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_NO_DATA   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       segment_last;
        logic       done_res;
        logic [1:0] status;
    } result_t;

endpackage

>>> rtl/jase_in_stage.sv
// input register stage of the segment extractor
// depends on jase_pkg
module jase_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  jase_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output jase_pkg::item_t item
);

    logic            valid_reg;
    jase_pkg::item_t item_reg;

    // no transfer is taken while reset is held
    assign s_tready   = aresetn && (!valid_reg || take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> rtl/jase_step.sv
// per-byte parser: state registers and single-pass next-state logic
// depends on jase_pkg
module jase_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_marker,
    input  logic              fire,
    input  jase_pkg::item_t   item,
    output logic              has_result,
    output jase_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_SOI_HI,
        PH_SOI_LO,
        PH_SCAN,
        PH_LEN,
        PH_ID,
        PH_PAY,
        PH_SKIP,
        PH_REJECT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  first_reg, first_next;
    logic        half_reg, half_next;
    logic [15:0] seg_len_reg, seg_len_next;
    logic [15:0] left_reg, left_next;
    logic        id_match_reg, id_match_next;
    logic        found_reg, found_next;
    logic        failed_reg, failed_next;
    logic [7:0]  marker_reg;

    logic [15:0] seg_len_in;
    logic [15:0] left_dec;
    logic [15:0] id_pos;
    logic [15:0] remaining;
    logic        id_match_now;
    logic [15:0] short_left;

    assign seg_len_in = {first_reg, item.data_byte};
    assign left_dec   = (left_reg != 16'd0) ? left_reg - 16'd1 : left_reg;
    assign id_pos     = jase_pkg::ID_COUNT - left_reg;
    assign remaining  = seg_len_reg - jase_pkg::MIN_ID_SEG_LEN;
    assign short_left = (seg_len_in >= jase_pkg::LEN_FIELD_SIZE) ?
                        seg_len_in - jase_pkg::LEN_FIELD_SIZE : 16'd0;
    assign id_match_now = id_match_reg &&
                          (item.data_byte == jase_pkg::ID_TAB[id_pos[3:0]]);

    always_comb begin
        phase_next    = phase_reg;
        first_next    = first_reg;
        half_next     = half_reg;
        seg_len_next  = seg_len_reg;
        left_next     = left_reg;
        id_match_next = id_match_reg;
        found_next    = found_reg;
        failed_next   = failed_reg;
        result        = '0;

        case (phase_reg)
            PH_SOI_HI: begin
                first_next = item.data_byte;
                phase_next = PH_SOI_LO;
            end
            PH_SOI_LO: begin
                if (first_reg == jase_pkg::MARKER_PREFIX &&
                    item.data_byte == jase_pkg::SOI_CODE) begin
                    phase_next = PH_SCAN;
                    half_next  = 1'b0;
                end else begin
                    failed_next = 1'b1;
                    phase_next  = PH_REJECT;
                end
            end
            PH_SCAN: begin
                if (!half_reg) begin
                    first_next = item.data_byte;
                    half_next  = 1'b1;
                end else begin
                    half_next = 1'b0;
                    if (first_reg == jase_pkg::MARKER_PREFIX &&
                        item.data_byte == marker_reg) begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (!half_reg) begin
                    first_next = item.data_byte;
                    half_next  = 1'b1;
                end else begin
                    half_next    = 1'b0;
                    seg_len_next = seg_len_in;
                    if (seg_len_in >= jase_pkg::MIN_ID_SEG_LEN) begin
                        left_next     = jase_pkg::ID_COUNT;
                        id_match_next = 1'b1;
                        phase_next    = PH_ID;
                    end else begin
                        left_next  = short_left;
                        phase_next = (short_left != 16'd0) ? PH_SKIP : PH_SCAN;
                    end
                end
            end
            PH_ID: begin
                id_match_next = id_match_now;
                left_next     = left_dec;
                if (left_dec == 16'd0) begin
                    left_next = remaining;
                    if (remaining == 16'd0) begin
                        phase_next = PH_SCAN;
                    end else begin
                        phase_next = id_match_now ? PH_PAY : PH_SKIP;
                    end
                end
            end
            PH_PAY: begin
                result.payload_byte  = item.data_byte;
                result.payload_valid = 1'b1;
                found_next           = 1'b1;
                left_next            = left_dec;
                if (left_dec == 16'd0) begin
                    result.segment_last = 1'b1;
                    phase_next          = PH_SCAN;
                end
            end
            PH_SKIP: begin
                left_next = left_dec;
                if (left_dec == 16'd0) begin
                    phase_next = PH_SCAN;
                end
            end
            PH_REJECT: begin
            end
            default: begin
            end
        endcase

        // end of file: report and re-arm for the next one
        if (item.last_byte) begin
            result.done_res = 1'b1;
            if (failed_next) begin
                result.status = jase_pkg::ST_NOT_JPEG;
            end else if (phase_next != PH_SCAN) begin
                result.status = jase_pkg::ST_TRUNCATED;
            end else if (found_next) begin
                result.status = jase_pkg::ST_OK;
            end else begin
                result.status = jase_pkg::ST_NO_DATA;
            end
            phase_next    = PH_SOI_HI;
            first_next    = 8'd0;
            half_next     = 1'b0;
            seg_len_next  = 16'd0;
            left_next     = 16'd0;
            id_match_next = 1'b1;
            found_next    = 1'b0;
            failed_next   = 1'b0;
        end
    end

    assign has_result = result.payload_valid || result.done_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SOI_HI;
            first_reg    <= 8'd0;
            half_reg     <= 1'b0;
            seg_len_reg  <= 16'd0;
            left_reg     <= 16'd0;
            id_match_reg <= 1'b1;
            found_reg    <= 1'b0;
            failed_reg   <= 1'b0;
            marker_reg   <= jase_pkg::APP_MARKER_RESET;
        end else begin
            if (fire) begin
                phase_reg    <= phase_next;
                first_reg    <= first_next;
                half_reg     <= half_next;
                seg_len_reg  <= seg_len_next;
                left_reg     <= left_next;
                id_match_reg <= id_match_next;
                found_reg    <= found_next;
                failed_reg   <= failed_next;
            end
            if (cfg_write) begin
                marker_reg <= cfg_marker;
            end
        end
    end

endmodule

>>> rtl/jase_out_stage.sv
// result register stage of the segment extractor
// depends on jase_pkg
module jase_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  jase_pkg::result_t result,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output jase_pkg::result_t m_result
);

    logic              valid_reg;
    jase_pkg::result_t result_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

>>> rtl/jpeg_app_segment_extractor_unit.sv
// path: an input byte is registered in the input stage, and its result, if any,
//   is then loaded into the result register that drives the output
// throughput: one byte per cycle through the single-pass parser; bytes with no
//   result leave no output, a stalled result holds the input back
// reset: synchronous, active low; parser expects start of image, marker e0
// top level; depends on jase_pkg, jase_in_stage, jase_step, jase_out_stage
module jpeg_app_segment_extractor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // extracted payload and final status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [9:8] status, rest zero
    output logic        m_tlast,   // segment_last
    output logic [1:0]  m_tuser,   // [0] payload_valid, [1] done_res
    // application marker register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    jase_pkg::item_t   s_item;
    jase_pkg::item_t   item;
    jase_pkg::result_t result;
    jase_pkg::result_t m_result;
    logic              item_valid;
    logic              has_result;
    logic              out_free;
    logic              fire;

    // register writes are taken whenever reset is released
    assign cfg_ready = aresetn;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    // a byte moves on when its result, if any, has room in the result register
    assign fire = item_valid && (out_free || !has_result);

    jase_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    jase_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_marker (cfg_data),
        .fire       (fire),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    jase_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && has_result),
        .result   (result),
        .can_load (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // pack the result transfer
    assign m_tdata = {6'd0, m_result.status, m_result.payload_byte};
    assign m_tlast = m_result.segment_last;
    assign m_tuser = {m_result.done_res, m_result.payload_valid};

endmodule

>>> rtl/jase_checker.sv
// port-level checks on the result channel of the segment extractor
// depends on jpeg_app_segment_extractor_unit_assert.svh and the top level
`include "jpeg_app_segment_extractor_unit_assert.svh"

module jase_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // a stalled result stays valid and its data holds
    `JASE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every transfer carries a payload byte or a status
    `JASE_ASSERT_NOW(a_reason, aclk, aresetn, m_tvalid, m_tuser[0] || m_tuser[1])

    // no payload means zero byte and no segment end
    `JASE_ASSERT_NOW(a_no_pay, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0 && !m_tlast)

    // status only with the final report, padding always zero
    `JASE_ASSERT_NOW(a_status, aclk, aresetn, m_tvalid, (m_tuser[1] || m_tdata[9:8] == 2'd0) && m_tdata[15:10] == 6'd0)

endmodule

bind jpeg_app_segment_extractor_unit jase_checker u_jase_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
